### src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_SAME(lbl, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) else $error(msg);

`endif

### src/mik_pkg.sv
`default_nettype none
package mik_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned ZW = 26;
  localparam int unsigned XW = 28;
  localparam logic [16:0] InvGain = 17'd39797;

  typedef enum logic [2:0] {
    REG_FRAME_MODE     = 3'd0,
    REG_MAX_SPEED      = 3'd1,
    REG_MAX_YAW_RATE   = 3'd2,
    REG_HALF_LENGTH    = 3'd3,
    REG_HALF_WIDTH     = 3'd4,
    REG_INVERSE_RADIUS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   w;
    logic                 rot;
    logic signed [15:0]   vx;
    logic signed [15:0]   vy;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    a = '0;
    case (i)
      4'd0:  a = 26'sd2097152;
      4'd1:  a = 26'sd1238021;
      4'd2:  a = 26'sd654136;
      4'd3:  a = 26'sd332050;
      4'd4:  a = 26'sd166669;
      4'd5:  a = 26'sd83416;
      4'd6:  a = 26'sd41718;
      4'd7:  a = 26'sd20860;
      4'd8:  a = 26'sd10430;
      4'd9:  a = 26'sd5215;
      4'd10: a = 26'sd2608;
      4'd11: a = 26'sd1304;
      4'd12: a = 26'sd652;
      4'd13: a = 26'sd326;
      4'd14: a = 26'sd163;
      4'd15: a = 26'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### src/mik_cell.sv
`default_nettype none
module mik_cell #(
  parameter logic [3:0] STAGE = 4'd0
) (
  input  wire logic            clk,
  input  wire logic            v_in,
  input  wire mik_pkg::cordic_t d_in,
  output      logic            v_out,
  output      mik_pkg::cordic_t d_out,
  input  wire logic            rst_n
);
  import mik_pkg::*;

  cordic_t d_nxt;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = d_in.y >>> STAGE;
    dy = d_in.x >>> STAGE;
    d_nxt = d_in;
    if (!d_in.z[ZW-1]) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - atan_turn(STAGE);
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + atan_turn(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_out <= 1'b0;
    else v_out <= v_in;
    d_out <= d_nxt;
  end
endmodule
`default_nettype wire

### src/mik_wheel.sv
`default_nettype none
module mik_wheel (
  input  wire logic               clk,
  input  wire logic signed [33:0] lin,
  input  wire logic        [15:0] inv,
  output      logic signed [23:0] wheel
);
  logic signed [33:0] lin_r;
  logic signed [51:0] prod;
  logic signed [29:0] rnd;
  logic signed [23:0] wheel_nxt;

  always_comb begin
    prod = lin_r * $signed({1'b0, inv});
    rnd = 30'((prod + 52'sd2097152) >>> 22);
    if (rnd > 30'sd8388607) wheel_nxt = 24'sh7FFFFF;
    else if (rnd < -30'sd8388608) wheel_nxt = 24'sh800000;
    else wheel_nxt = rnd[23:0];
  end

  always_ff @(posedge clk) begin
    lin_r <= lin;
    wheel <= wheel_nxt;
  end
endmodule
`default_nettype wire

### src/mecanum_inverse_kinematics.sv
`default_nettype none
// Channel  | Ports                                        | Handshake
// input    | in_velocity_x/y, in_yaw_rate, in_turret_angle | start & !busy
// result   | out_wheel_*                                  | out_strobe, one cycle
// config   | cfg_we, cfg_index, cfg_data                  | cfg_we
// One item per cycle; busy stays low. Pipeline: one entry stage,
// sixteen CORDIC cells, gain, clamp, sum and a two-stage wheel multiply.
// Reset clears valid bits and restores register defaults.
// Results cannot be stalled.
module mecanum_inverse_kinematics (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [15:0] in_velocity_x,
  input  wire logic signed [15:0] in_velocity_y,
  input  wire logic signed [15:0] in_yaw_rate,
  input  wire logic        [15:0] in_turret_angle,
  output      logic               out_strobe,
  output      logic signed [23:0] out_wheel_rear_left,
  output      logic signed [23:0] out_wheel_front_left,
  output      logic signed [23:0] out_wheel_front_right,
  output      logic signed [23:0] out_wheel_rear_right,
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [15:0] cfg_data
);
  import mik_pkg::*;

  logic        frame_mode_r;
  logic [14:0] max_speed_r, max_yaw_r, half_len_r, half_wid_r;
  logic [15:0] inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= 1'b1;
      max_speed_r <= 15'd32767;
      max_yaw_r <= 15'd32767;
      half_len_r <= 15'd3277;
      half_wid_r <= 15'd3277;
      inv_r <= 16'd3368;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_MODE:     frame_mode_r <= cfg_data[0];
        REG_MAX_SPEED:      max_speed_r <= cfg_data[14:0];
        REG_MAX_YAW_RATE:   max_yaw_r <= cfg_data[14:0];
        REG_HALF_LENGTH:    half_len_r <= cfg_data[14:0];
        REG_HALF_WIDTH:     half_wid_r <= cfg_data[14:0];
        REG_INVERSE_RADIUS: inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // entry: quadrant turn and residual angle
  logic [1:0] q;
  logic signed [16:0] qx, qy;
  logic signed [17:0] zres;
  cordic_t ent_nxt;
  logic [16:0] asum;

  always_comb begin
    asum = {1'b0, in_turret_angle} + 17'd8192;
    q = asum[15:14];
    zres = $signed({2'b0, in_turret_angle}) - $signed({2'b0, q, 14'd0});
    if (zres >= 18'sd32768) zres = zres - 18'sd65536;
    qx = 17'(in_velocity_x);
    qy = 17'(in_velocity_y);
    case (q)
      2'd1: begin qx = -17'(in_velocity_y); qy = 17'(in_velocity_x); end
      2'd2: begin qx = -17'(in_velocity_x); qy = -17'(in_velocity_y); end
      2'd3: begin qx = 17'(in_velocity_y); qy = -17'(in_velocity_x); end
      default: ;
    endcase
    ent_nxt.x = XW'(qx) <<< 8;
    ent_nxt.y = XW'(qy) <<< 8;
    ent_nxt.z = ZW'(zres) <<< 8;
    ent_nxt.w = in_yaw_rate;
    ent_nxt.rot = frame_mode_r;
    ent_nxt.vx = in_velocity_x;
    ent_nxt.vy = in_velocity_y;
  end

  logic    v_c [0:CordicStages];
  cordic_t d_c [0:CordicStages];

  always_ff @(posedge clk) begin
    if (!rst_n) v_c[0] <= 1'b0;
    else v_c[0] <= start;
    d_c[0] <= ent_nxt;
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cell
    mik_cell #(.STAGE(4'(g))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .v_in(v_c[g]), .d_in(d_c[g]),
      .v_out(v_c[g+1]), .d_out(d_c[g+1])
    );
  end

  // gain removal, or raw velocity pass-through when frame mode is off
  cordic_t fin;
  assign fin = d_c[CordicStages];
  logic signed [45:0] gx, gy;
  logic signed [16:0] rx_r, ry_r;
  logic signed [15:0] w1_r;
  logic v1_r;
  always_comb begin
    gx = 46'((46'(fin.x) * $signed({1'b0, InvGain}) + 46'sd8388608) >>> 24);
    gy = 46'((46'(fin.y) * $signed({1'b0, InvGain}) + 46'sd8388608) >>> 24);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v_c[CordicStages];
    rx_r <= fin.rot ? gx[16:0] : 17'(fin.vx);
    ry_r <= fin.rot ? gy[16:0] : 17'(fin.vy);
    w1_r <= fin.w;
  end

  // clamp, and the half-length plus half-width sum
  function automatic logic signed [16:0] clampf(input logic signed [16:0] v,
                                                input logic [14:0] lim);
    logic signed [16:0] l;
    l = $signed({2'b0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  logic signed [16:0] cx_r, cy_r, cw_r;
  logic [15:0] rr_r;
  logic v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    cx_r <= clampf(rx_r, max_speed_r);
    cy_r <= clampf(ry_r, max_speed_r);
    cw_r <= clampf(17'(w1_r), max_yaw_r);
    rr_r <= {1'b0, half_len_r} + {1'b0, half_wid_r};
  end

  logic signed [33:0] wr_r, sum_r, dif_r;
  logic v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    wr_r <= 34'(cw_r * $signed({1'b0, rr_r}));
    sum_r <= 34'(cx_r + cy_r) <<< 14;
    dif_r <= 34'(cx_r - cy_r) <<< 14;
  end

  logic signed [33:0] l0, l1, l2, l3;
  assign l0 = sum_r - wr_r;
  assign l1 = dif_r - wr_r;
  assign l2 = -(sum_r + wr_r);
  assign l3 = -(dif_r + wr_r);

  mik_wheel u_w0 (.clk(clk), .lin(l0), .inv(inv_r), .wheel(out_wheel_rear_left));
  mik_wheel u_w1 (.clk(clk), .lin(l1), .inv(inv_r), .wheel(out_wheel_front_left));
  mik_wheel u_w2 (.clk(clk), .lin(l2), .inv(inv_r), .wheel(out_wheel_front_right));
  mik_wheel u_w3 (.clk(clk), .lin(l3), .inv(inv_r), .wheel(out_wheel_rear_right));

  logic v4_r, v5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end
  assign out_strobe = v5_r;
endmodule
`default_nettype wire

### src/mik_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mik_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe
);
  `CHK_SAME(a_never_busy, rst_n, 1'b1, !busy, "busy raised")
  `CHK_NEXT(a_reset_quiet, 1'b1, !rst_n, !out_strobe, "strobe after reset")
  `CHK_SAME(a_no_early, rst_n, !$past(rst_n), !out_strobe, "strobe right after reset")
  `CHK_SAME(a_start_known, rst_n, 1'b1, !$isunknown(start), "start unknown")
endmodule

bind mecanum_inverse_kinematics mik_checker u_mik_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe)
);
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mik_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] w;
    logic [15:0]        angle;
  } command_t;

  typedef struct {
    logic signed [23:0] rear_left;
    logic signed [23:0] front_left;
    logic signed [23:0] front_right;
    logic signed [23:0] rear_right;
  } wheels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_velocity_x = '0;
  logic signed [15:0] in_velocity_y = '0;
  logic signed [15:0] in_yaw_rate = '0;
  logic [15:0] in_turret_angle = '0;
  logic out_strobe;
  logic signed [23:0] out_wheel_rear_left;
  logic signed [23:0] out_wheel_front_left;
  logic signed [23:0] out_wheel_front_right;
  logic signed [23:0] out_wheel_rear_right;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  mecanum_inverse_kinematics uut (.*);

  bit [0:0]  frame_mode_q = 1'b1;
  bit [14:0] max_speed_q = 15'd32767;
  bit [14:0] max_yaw_q = 15'd32767;
  bit [14:0] half_length_q = 15'd3277;
  bit [14:0] half_width_q = 15'd3277;
  bit [15:0] inv_radius_q = 16'd3368;

  command_t pending_cmds[$];
  wheels_t  expected_wheels[$];
  command_t cur_cmd;
  int       gap = 0;
  bit       dense = 1'b0;
  int       errors = 0;

  const longint AtanTurns[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                  41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                  163, 81};

  initial forever #10 clk = ~clk;

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [23:0] scale_wheel(longint lin);
    longint r;
    r = (lin * longint'(inv_radius_q) + (64'sd1 <<< 21)) >>> 22;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  function automatic wheels_t solve_wheels(command_t c);
    longint x, y, z, t, dx, dy, w, wr, sum, dif;
    int q;
    wheels_t res;
    x = c.vx;
    y = c.vy;
    w = c.w;
    if (frame_mode_q) begin
      q = ((int'(c.angle) + 8192) >> 14) & 3;
      z = (longint'(c.angle) - q * 16384) * 256;
      if (z >= 32768 * 256) z -= 65536 * 256;
      case (q)
        1: begin t = x; x = -y; y = t; end
        2: begin x = -x; y = -y; end
        3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      x *= 256;
      y *= 256;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= AtanTurns[i];
        end else begin
          x += dx; y -= dy; z += AtanTurns[i];
        end
      end
      x = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
      y = (y * 39797 + (64'sd1 <<< 23)) >>> 24;
    end
    x = clamp_sym(x, max_speed_q);
    y = clamp_sym(y, max_speed_q);
    w = clamp_sym(w, max_yaw_q);
    wr = w * (longint'(half_length_q) + longint'(half_width_q));
    sum = (x + y) * 16384;
    dif = (x - y) * 16384;
    res.rear_left   = scale_wheel(sum - wr);
    res.front_left  = scale_wheel(dif - wr);
    res.front_right = scale_wheel(-(sum + wr));
    res.rear_right  = scale_wheel(-(dif + wr));
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (dense || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    command_t nx;
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) expected_wheels.push_back(solve_wheels(cur_cmd));
      if (start && busy) begin
      end else if (gap != 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (pending_cmds.size() != 0) begin
        nx = pending_cmds.pop_front();
        cur_cmd <= nx;
        in_velocity_x <= nx.vx;
        in_velocity_y <= nx.vy;
        in_yaw_rate <= nx.w;
        in_turret_angle <= nx.angle;
        start <= 1'b1;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    wheels_t e;
    if (rst_n && out_strobe) begin
      if (expected_wheels.size() == 0) begin
        $display("%0t unexpected result rl=%0d fl=%0d fr=%0d rr=%0d", $time,
                 out_wheel_rear_left, out_wheel_front_left,
                 out_wheel_front_right, out_wheel_rear_right);
        errors++;
      end else begin
        e = expected_wheels.pop_front();
        if (out_wheel_rear_left !== e.rear_left) begin
          $display("%0t rear_left exp %0d got %0d", $time, e.rear_left, out_wheel_rear_left);
          errors++;
        end
        if (out_wheel_front_left !== e.front_left) begin
          $display("%0t front_left exp %0d got %0d", $time, e.front_left,
                   out_wheel_front_left);
          errors++;
        end
        if (out_wheel_front_right !== e.front_right) begin
          $display("%0t front_right exp %0d got %0d", $time, e.front_right,
                   out_wheel_front_right);
          errors++;
        end
        if (out_wheel_rear_right !== e.rear_right) begin
          $display("%0t rear_right exp %0d got %0d", $time, e.rear_right,
                   out_wheel_rear_right);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_FRAME_MODE:     frame_mode_q = data[0];
      REG_MAX_SPEED:      max_speed_q = data[14:0];
      REG_MAX_YAW_RATE:   max_yaw_q = data[14:0];
      REG_HALF_LENGTH:    half_length_q = data[14:0];
      REG_HALF_WIDTH:     half_width_q = data[14:0];
      REG_INVERSE_RADIUS: inv_radius_q = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_wheels.size() != 0);
  endtask

  task automatic push_cmd(int vx, int vy, int w, int angle);
    command_t c;
    c.vx = 16'(vx);
    c.vy = 16'(vy);
    c.w = 16'(w);
    c.angle = 16'(angle);
    pending_cmds.push_back(c);
  endtask

  function automatic int pick_speed();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(2000) - 1000;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic push_random(int n);
    int a;
    repeat (n) begin
      if ($urandom_range(3) == 0)
        a = ($urandom_range(3) * 16384 + 8192 + $urandom_range(3) - 2) & 16'hFFFF;
      else
        a = $urandom_range(65535);
      push_cmd(pick_speed(), pick_speed(), pick_speed(), a);
    end
  endtask

  task automatic run_phase(logic [15:0] fm, logic [15:0] ms, logic [15:0] my,
                           logic [15:0] hl, logic [15:0] hw, logic [15:0] ir, int n);
    write_reg(REG_FRAME_MODE, fm);
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_MAX_YAW_RATE, my);
    write_reg(REG_HALF_LENGTH, hl);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_INVERSE_RADIUS, ir);
    write_reg(RegUnused, 16'hFFFF);
    dense = ($urandom_range(2) == 0);
    push_random(n);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    push_cmd(0, 0, 0, 0);
    push_cmd(32767, 32767, 32767, 0);
    push_cmd(-32768, -32768, -32768, 0);
    push_cmd(32767, -32768, 0, 0);
    push_cmd(-32768, 32767, 100, 0);
    push_cmd(1000, 500, -200, 8191);
    push_cmd(1000, 500, -200, 8192);
    push_cmd(1000, 500, -200, 16384);
    push_cmd(1000, 500, -200, 24575);
    push_cmd(1000, 500, -200, 24576);
    push_cmd(1000, 500, -200, 32768);
    push_cmd(1000, 500, -200, 40960);
    push_cmd(1000, 500, -200, 49152);
    push_cmd(1000, 500, -200, 57343);
    push_cmd(1000, 500, -200, 57344);
    push_cmd(1000, 500, -200, 65535);
    push_cmd(-32768, -32768, 32767, 32768);
    push_cmd(32767, 32767, -32768, 16384);
    push_cmd(-1, -1, -1, 65535);
    push_cmd(1, 0, 0, 1);
    push_random(80);
    drain();
    run_phase(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 90);
    run_phase(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 40);
    run_phase(16'h0001, 16'h8000, 16'h0001, 16'd3277, 16'd3277, 16'hFFFF, 60);
    run_phase(16'h0000, 16'd1000, 16'd2000, 16'd1500, 16'd2500, 16'd3368, 80);
    repeat (3)
      run_phase(16'($urandom_range(1)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)), 85);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
